FILE: design/rmq_pkg.sv
package rmq_pkg;

    // Q2.14 / Q1.14 unit value
    localparam int QOne = 16384;

    // widths
    localparam int VW   = 19;              // signed width of a branch vector element
    localparam int AW   = 18;              // magnitude of a branch vector element
    localparam int SW   = 37;              // sum of four squares
    localparam int RW   = 66;              // radicand S * 2^28, even width for bit pairs
    localparam int NW   = 33;              // square root of radicand
    localparam int DNW  = 46;              // dividend |v| * 2^28 + N/2
    localparam int QW   = 15;              // saturated quotient magnitude

    // pipeline depths
    localparam int SqrtSteps = NW;         // one result bit per stage
    localparam int DivSteps  = DNW;        // one quotient bit per stage

    // front queue depth
    localparam int FifoDepth = 4;
    localparam int FifoAw    = $clog2(FifoDepth);

    // classified item passed from front to back
    typedef struct packed {
        logic                 degen;
        logic [3:0]           neg;
        logic [3:0][AW-1:0]   mag;
    } t_cls;

    // item carried through the back end
    typedef struct packed {
        logic                 degen;
        logic [3:0]           neg;
        logic [3:0][AW-1:0]   mag;
    } t_tag;

    typedef struct packed {
        logic [15:0] w;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] z;
        logic        degen;
    } t_res;

endpackage

FILE: design/rotation_matrix_to_quaternion_core.sv
// Channel   Dir  Handshake          Payload
// s_axis    in   tvalid/tready      tdata: r00 r01 r02 r10 r11 r12 r20 r21 r22
// m_axis    out  tvalid/tready      tdata: quat_w quat_x quat_y quat_z; tuser: degenerate
//
// One matrix accepted per cycle while the front register can pass its item on; the result
// passes the queue, the squares and sum stages, the square root pipeline, the divider
// pipeline and the output register; the front register loads at the accepting edge.
// Latency is set by the bit-per-stage square root and divider pipelines.
// A 4-entry queue lets the front keep accepting while the back end stalls.
// Reset (synchronous, active low) empties every stage and the queue.
module rotation_matrix_to_quaternion_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [143:0] s_axis_tdata,   // r00 r01 r02 r10 r11 r12 r20 r21 r22
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [63:0]  m_axis_tdata,   // quat_w quat_x quat_y quat_z
    output logic         m_axis_tuser    // degenerate
);
    logic          f_valid, f_ready, q_valid, q_ready;
    rmq_pkg::t_cls f_cls, q_cls;
    rmq_pkg::t_res res;

    rmq_front u_front (
        .i_clk, .i_rst_n,
        .i_valid (s_axis_tvalid), .o_ready (s_axis_tready), .i_data (s_axis_tdata),
        .o_valid (f_valid), .i_ready (f_ready), .o_cls (f_cls)
    );

    rmq_fifo u_fifo (
        .i_clk, .i_rst_n,
        .i_valid (f_valid), .o_ready (f_ready), .i_cls (f_cls),
        .o_valid (q_valid), .i_ready (q_ready), .o_cls (q_cls)
    );

    rmq_back u_back (
        .i_clk, .i_rst_n,
        .i_valid (q_valid), .o_ready (q_ready), .i_cls (q_cls),
        .o_valid (m_axis_tvalid), .i_ready (m_axis_tready), .o_res (res)
    );

    assign m_axis_tdata = {res.z, res.y, res.x, res.w};
    assign m_axis_tuser = res.degen;

endmodule

FILE: design/rmq_front.sv
// Branch choice and branch vector build (one register stage)
module rmq_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [143:0]       i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output rmq_pkg::t_cls      o_cls
);
    logic signed [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
    logic signed [17:0] t;
    logic signed [rmq_pkg::VW-1:0] rad;
    logic signed [rmq_pkg::VW-1:0] v [4];
    logic signed [rmq_pkg::VW-1:0] a00, a11, a22;
    logic signed [rmq_pkg::VW-1:0] qone;
    rmq_pkg::t_cls n_cls;
    rmq_pkg::t_cls r_cls;
    logic          r_valid;

    assign {m22, m21, m20, m12, m11, m10, m02, m01, m00} = i_data;
    assign a00  = rmq_pkg::VW'(m00);
    assign a11  = rmq_pkg::VW'(m11);
    assign a22  = rmq_pkg::VW'(m22);
    assign qone = rmq_pkg::VW'(rmq_pkg::QOne);
    assign t    = 18'(m00) + 18'(m11) + 18'(m22);

    // Shepperd branch selection
    always_comb begin
        if (t > 18'sd0) begin
            rad  = qone + rmq_pkg::VW'(t);
            v[0] = rad;
            v[1] = rmq_pkg::VW'(m21) - rmq_pkg::VW'(m12);
            v[2] = rmq_pkg::VW'(m02) - rmq_pkg::VW'(m20);
            v[3] = rmq_pkg::VW'(m10) - rmq_pkg::VW'(m01);
        end else if (m00 > m11 && m00 > m22) begin
            rad  = qone + a00 - a11 - a22;
            v[0] = rmq_pkg::VW'(m21) - rmq_pkg::VW'(m12);
            v[1] = rad;
            v[2] = rmq_pkg::VW'(m01) + rmq_pkg::VW'(m10);
            v[3] = rmq_pkg::VW'(m02) + rmq_pkg::VW'(m20);
        end else if (m11 > m22) begin
            rad  = qone + a11 - a00 - a22;
            v[0] = rmq_pkg::VW'(m02) - rmq_pkg::VW'(m20);
            v[1] = rmq_pkg::VW'(m01) + rmq_pkg::VW'(m10);
            v[2] = rad;
            v[3] = rmq_pkg::VW'(m12) + rmq_pkg::VW'(m21);
        end else begin
            rad  = qone + a22 - a00 - a11;
            v[0] = rmq_pkg::VW'(m10) - rmq_pkg::VW'(m01);
            v[1] = rmq_pkg::VW'(m02) + rmq_pkg::VW'(m20);
            v[2] = rmq_pkg::VW'(m12) + rmq_pkg::VW'(m21);
            v[3] = rad;
        end
    end

    // sign / magnitude split
    always_comb begin
        n_cls.degen = (rad <= 0);
        for (int i = 0; i < 4; i++) begin
            n_cls.neg[i] = v[i][rmq_pkg::VW-1];
            n_cls.mag[i] = v[i][rmq_pkg::VW-1] ? rmq_pkg::AW'(-v[i])
                                               : rmq_pkg::AW'(v[i]);
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_cls <= n_cls;
        end
    end

    assign o_valid = r_valid;
    assign o_cls   = r_cls;

endmodule

FILE: design/rmq_fifo.sv
// Short queue between front and back
module rmq_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  rmq_pkg::t_cls i_cls,
    output logic          o_valid,
    input  logic          i_ready,
    output rmq_pkg::t_cls o_cls
);
    rmq_pkg::t_cls r_mem [rmq_pkg::FifoDepth];
    logic [rmq_pkg::FifoAw-1:0] r_wp, r_rp;
    logic [rmq_pkg::FifoAw:0]   r_cnt;
    logic push, pop;

    assign o_ready = (r_cnt != (rmq_pkg::FifoAw+1)'(rmq_pkg::FifoDepth));
    assign o_valid = (r_cnt != '0);
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign o_cls   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (rmq_pkg::FifoAw+1)'(push) - (rmq_pkg::FifoAw+1)'(pop);
        end
        if (push) begin
            r_mem[r_wp] <= i_cls;
        end
    end

    property p_no_under;
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> !pop;
    endproperty
    a_no_under: assert property (p_no_under) else $error("fifo underflow");

    property p_no_over;
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == (rmq_pkg::FifoAw+1)'(rmq_pkg::FifoDepth)) |-> !push;
    endproperty
    a_no_over: assert property (p_no_over) else $error("fifo overflow");

    property p_cnt;
        @(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> (r_cnt == $past(r_cnt) + 1'b1);
    endproperty
    a_cnt: assert property (p_cnt) else $error("fifo count");

    property p_wp;
        @(posedge i_clk) disable iff (!i_rst_n)
        !push |=> $stable(r_wp);
    endproperty
    a_wp: assert property (p_wp) else $error("write pointer moved");

endmodule

FILE: design/rmq_back.sv
// Back end: squares, pipelined sqrt, four pipelined dividers, saturation.
// Advances as a whole when the output register can take an item.
module rmq_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  rmq_pkg::t_cls i_cls,
    output logic          o_valid,
    input  logic          i_ready,
    output rmq_pkg::t_res o_res
);
    logic adv;

    // stage A: squares
    logic                r_va;
    rmq_pkg::t_tag       r_ta;
    logic [2*rmq_pkg::AW-1:0] r_sq [4];

    // stage B: sum
    logic                r_vb;
    rmq_pkg::t_tag       r_tb;
    logic [rmq_pkg::SW-1:0] r_sum;

    // sqrt pipeline (restoring, one bit per stage)
    logic                   r_vs   [rmq_pkg::SqrtSteps+1];
    rmq_pkg::t_tag          r_ts   [rmq_pkg::SqrtSteps+1];
    logic [rmq_pkg::RW-1:0] r_rem  [rmq_pkg::SqrtSteps+1];
    logic [rmq_pkg::NW-1:0] r_root [rmq_pkg::SqrtSteps+1];
    logic [rmq_pkg::RW-1:0] r_rad  [rmq_pkg::SqrtSteps+1];

    // divider pipeline
    logic                    r_vd [rmq_pkg::DivSteps+1];
    rmq_pkg::t_tag           r_td [rmq_pkg::DivSteps+1];
    logic [rmq_pkg::NW-1:0]  r_dn [rmq_pkg::DivSteps+1];
    logic [rmq_pkg::DNW-1:0] r_dr [4][rmq_pkg::DivSteps+1];
    logic [rmq_pkg::NW:0]    r_dp [4][rmq_pkg::DivSteps+1];
    logic [rmq_pkg::DNW-1:0] r_dq [4][rmq_pkg::DivSteps+1];

    logic          r_vo;
    rmq_pkg::t_res r_res;

    assign adv     = !r_vo || i_ready;
    assign o_ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else if (adv) begin
            r_va <= i_valid;
            r_vb <= r_va;
        end
        if (adv) begin
            r_ta <= i_cls;
            for (int i = 0; i < 4; i++) begin
                r_sq[i] <= (2*rmq_pkg::AW)'(i_cls.mag[i]) * (2*rmq_pkg::AW)'(i_cls.mag[i]);
            end
            r_tb  <= r_ta;
            r_sum <= rmq_pkg::SW'(r_sq[0]) + rmq_pkg::SW'(r_sq[1])
                   + rmq_pkg::SW'(r_sq[2]) + rmq_pkg::SW'(r_sq[3]);
        end
    end

    // sqrt stage 0 load
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vs[0] <= 1'b0;
        end else if (adv) begin
            r_vs[0] <= r_vb;
        end
        if (adv) begin
            r_ts[0]   <= r_tb;
            r_rad[0]  <= rmq_pkg::RW'(r_sum) << 28;
            r_rem[0]  <= '0;
            r_root[0] <= '0;
        end
    end

    // bit k (from top): rem = rem*4 + next two radicand bits; try (root*4+1)
    for (genvar k = 0; k < rmq_pkg::SqrtSteps; k++) begin : g_sq
        logic [rmq_pkg::RW+1:0] trial, rem2;
        assign rem2  = {r_rem[k], r_rad[k][rmq_pkg::RW-1 -: 2]};
        assign trial = (rmq_pkg::RW+2)'({r_root[k], 2'b01});
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vs[k+1] <= 1'b0;
            end else if (adv) begin
                r_vs[k+1] <= r_vs[k];
            end
            if (adv) begin
                r_ts[k+1]  <= r_ts[k];
                r_rad[k+1] <= r_rad[k] << 2;
                if (rem2 >= trial) begin
                    r_rem[k+1]  <= rmq_pkg::RW'(rem2 - trial);
                    r_root[k+1] <= {r_root[k][rmq_pkg::NW-2:0], 1'b1};
                end else begin
                    r_rem[k+1]  <= rmq_pkg::RW'(rem2);
                    r_root[k+1] <= {r_root[k][rmq_pkg::NW-2:0], 1'b0};
                end
            end
        end
    end

    // divider load: dividend = |v|<<28 + N/2, N forced >= 1
    logic [rmq_pkg::NW-1:0] nrm;
    assign nrm = (r_root[rmq_pkg::SqrtSteps] == '0) ? rmq_pkg::NW'(1)
                                                    : r_root[rmq_pkg::SqrtSteps];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vd[0] <= 1'b0;
        end else if (adv) begin
            r_vd[0] <= r_vs[rmq_pkg::SqrtSteps];
        end
        if (adv) begin
            r_td[0] <= r_ts[rmq_pkg::SqrtSteps];
            r_dn[0] <= nrm;
            for (int i = 0; i < 4; i++) begin
                r_dr[i][0] <= (rmq_pkg::DNW'(r_ts[rmq_pkg::SqrtSteps].mag[i]) << 28)
                            + rmq_pkg::DNW'(nrm >> 1);
                r_dp[i][0] <= '0;
                r_dq[i][0] <= '0;
            end
        end
    end

    // restoring division, one quotient bit per stage
    for (genvar k = 0; k < rmq_pkg::DivSteps; k++) begin : g_dv
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vd[k+1] <= 1'b0;
            end else if (adv) begin
                r_vd[k+1] <= r_vd[k];
            end
            if (adv) begin
                r_td[k+1] <= r_td[k];
                r_dn[k+1] <= r_dn[k];
            end
        end
        for (genvar i = 0; i < 4; i++) begin : g_ln
            logic [rmq_pkg::NW+1:0] pr;
            assign pr = {r_dp[i][k], r_dr[i][k][rmq_pkg::DNW-1]};
            always_ff @(posedge i_clk) begin
                if (adv) begin
                    r_dr[i][k+1] <= r_dr[i][k] << 1;
                    if (pr >= (rmq_pkg::NW+2)'(r_dn[k])) begin
                        r_dp[i][k+1] <= (rmq_pkg::NW+1)'(pr - (rmq_pkg::NW+2)'(r_dn[k]));
                        r_dq[i][k+1] <= {r_dq[i][k][rmq_pkg::DNW-2:0], 1'b1};
                    end else begin
                        r_dp[i][k+1] <= (rmq_pkg::NW+1)'(pr);
                        r_dq[i][k+1] <= {r_dq[i][k][rmq_pkg::DNW-2:0], 1'b0};
                    end
                end
            end
        end
    end

    // saturate, sign, degenerate override
    logic [15:0] comp [4];
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            logic [15:0] m;
            m = (r_dq[i][rmq_pkg::DivSteps] > rmq_pkg::DNW'(rmq_pkg::QOne))
              ? 16'(rmq_pkg::QOne) : 16'(r_dq[i][rmq_pkg::DivSteps]);
            comp[i] = r_td[rmq_pkg::DivSteps].neg[i] ? 16'(-m) : m;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else if (adv) begin
            r_vo <= r_vd[rmq_pkg::DivSteps];
        end
        if (adv) begin
            if (r_td[rmq_pkg::DivSteps].degen) begin
                r_res <= '{w: 16'(rmq_pkg::QOne), x: '0, y: '0, z: '0, degen: 1'b1};
            end else begin
                r_res <= '{w: comp[0], x: comp[1], y: comp[2], z: comp[3], degen: 1'b0};
            end
        end
    end

    assign o_valid = r_vo;
    assign o_res   = r_res;

    property p_hold;
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_vo && !i_ready) |=> (r_vo && $stable(r_res));
    endproperty
    a_hold: assert property (p_hold) else $error("result changed while stalled");

    property p_degen;
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_vo && r_res.degen) |-> (r_res.w == 16'(rmq_pkg::QOne) && r_res.x == '0);
    endproperty
    a_degen: assert property (p_degen) else $error("degenerate not identity");

    property p_range;
        @(posedge i_clk) disable iff (!i_rst_n)
        r_vo |-> ($signed(r_res.w) <= 16'sd16384 && $signed(r_res.w) >= -16'sd16384);
    endproperty
    a_range: assert property (p_range) else $error("w out of range");

endmodule
